// ----- rtl/lrupr_pkg.sv -----
package lrupr_pkg;

  localparam int SLOT_W    = 3;
  localparam int CFG_W     = 4;
  localparam int FAULT_W   = 32;
  localparam int CFG_RESET = 3;

  typedef logic [CFG_W-1:0]   cfg_frames_t;
  typedef logic [SLOT_W-1:0]  slot_out_t;
  typedef logic [FAULT_W-1:0] fault_cnt_t;

endpackage

// ----- rtl/lrupr_ifs.sv -----
interface lrupr_in_if #(
  parameter int PAGE_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

interface lrupr_out_if import lrupr_pkg::*; #(
  parameter int PAGE_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  slot_out_t            slot_index;
  logic                 evicted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  fault_cnt_t           fault_total;

  modport source (output valid, output hit, output slot_index, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink (input valid, input hit, input slot_index, input evicted_valid,
                input evicted_page, input fault_total, output ready);
endinterface

interface lrupr_cfg_if import lrupr_pkg::*; ();
  logic        valid;
  logic        ready;
  cfg_frames_t frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink (input valid, input frames_in_use, output ready);
endinterface

// ----- rtl/lru_page_replacement_core.sv -----
// Each item is accepted in IDLE and then passes through SCAN, UPDATE and DELIVER. SCAN
// checks the frames in order (up to the first hit, else all active frames, at most NUM_FRAMES);
// the frame scan reads the page RAM one frame a cycle. A new item is taken only in IDLE, once
// DELIVER has loaded the last result, which may still wait at the output register.
// Reset: synchronous, active low; all frames empty, ranks and fault count zero,
// frames_in_use 3. The page RAM is not cleared.
module lru_page_replacement_core import lrupr_pkg::*; #(
  parameter int NUM_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  lrupr_in_if.sink      in_chan,
  lrupr_out_if.source   out_chan,
  lrupr_cfg_if.sink     cfg_chan
);

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_UPDATE  = 2'd2;
  localparam logic [1:0] S_DELIVER = 2'd3;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [PAGE_BITS-1:0] page_t;

  logic [1:0]  state_r, state_nxt;
  cfg_frames_t cfg_frames_r;
  page_t       page_r, page_nxt;
  idx_t        last_r, last_nxt;
  idx_t        scan_r, scan_nxt;
  logic        hit_r, hit_nxt;
  idx_t        slot_r, slot_nxt;
  logic        empty_found_r, empty_found_nxt;
  idx_t        empty_idx_r, empty_idx_nxt;
  idx_t        vict_idx_r, vict_idx_nxt;
  idx_t        vict_rank_r, vict_rank_nxt;
  page_t       vict_page_r, vict_page_nxt;
  logic        evict_valid_r, evict_valid_nxt;
  page_t       evict_page_r, evict_page_nxt;
  logic [NUM_FRAMES-1:0] valid_r, valid_nxt;
  idx_t        rank_r [NUM_FRAMES];
  idx_t        rank_nxt [NUM_FRAMES];
  fault_cnt_t  miss_r, miss_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_hit_r, out_hit_nxt;
  slot_out_t   out_slot_r, out_slot_nxt;
  logic        out_ev_valid_r, out_ev_valid_nxt;
  page_t       out_ev_page_r, out_ev_page_nxt;
  fault_cnt_t  out_fault_r, out_fault_nxt;

  idx_t        last_idx;
  idx_t        upd_slot;
  idx_t        old_rank;
  logic        age_all;
  logic        match;
  logic        ram_we;
  idx_t        ram_raddr;
  page_t       ram_rdata;
  logic [31:0] slot_wide;

  lrupr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (NUM_FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (upd_slot),
    .wdata (page_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.hit           = out_hit_r;
  assign out_chan.slot_index    = out_slot_r;
  assign out_chan.evicted_valid = out_ev_valid_r;
  assign out_chan.evicted_page  = out_ev_page_r;
  assign out_chan.fault_total   = out_fault_r;

  always_comb begin
    if (cfg_frames_r == '0) begin
      last_idx = '0;
    end else if (int'(cfg_frames_r) > NUM_FRAMES) begin
      last_idx = IDX_W'(NUM_FRAMES - 1);
    end else begin
      last_idx = IDX_W'(cfg_frames_r - CFG_W'(1));
    end
  end

  assign ram_raddr = (state_r == S_SCAN) ? scan_r + IDX_W'(1) : '0;
  assign match     = valid_r[scan_r] && (ram_rdata == page_r);

  always_comb begin
    if (hit_r) begin
      upd_slot = slot_r;
    end else if (empty_found_r) begin
      upd_slot = empty_idx_r;
    end else begin
      upd_slot = vict_idx_r;
    end
  end

  assign old_rank  = rank_r[upd_slot];
  assign age_all   = !hit_r && empty_found_r;
  assign ram_we    = (state_r == S_UPDATE) && !hit_r;
  assign slot_wide = 32'(slot_r);

  always_comb begin
    state_nxt       = state_r;
    page_nxt        = page_r;
    last_nxt        = last_r;
    scan_nxt        = scan_r;
    hit_nxt         = hit_r;
    slot_nxt        = slot_r;
    empty_found_nxt = empty_found_r;
    empty_idx_nxt   = empty_idx_r;
    vict_idx_nxt    = vict_idx_r;
    vict_rank_nxt   = vict_rank_r;
    vict_page_nxt   = vict_page_r;
    evict_valid_nxt = evict_valid_r;
    evict_page_nxt  = evict_page_r;
    valid_nxt       = valid_r;
    rank_nxt        = rank_r;
    miss_nxt        = miss_r;

    out_valid_nxt    = out_valid_r && !out_chan.ready;
    out_hit_nxt      = out_hit_r;
    out_slot_nxt     = out_slot_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_page_nxt  = out_ev_page_r;
    out_fault_nxt    = out_fault_r;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          page_nxt        = in_chan.page_number;
          last_nxt        = last_idx;
          scan_nxt        = '0;
          hit_nxt         = 1'b0;
          empty_found_nxt = 1'b0;
          vict_rank_nxt   = '0;
          vict_idx_nxt    = '0;
          state_nxt       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_nxt   = 1'b1;
          slot_nxt  = scan_r;
          state_nxt = S_UPDATE;
        end else begin
          if (!valid_r[scan_r] && !empty_found_r) begin
            empty_found_nxt = 1'b1;
            empty_idx_nxt   = scan_r;
          end
          if (rank_r[scan_r] >= vict_rank_r) begin
            vict_rank_nxt = rank_r[scan_r];
            vict_idx_nxt  = scan_r;
            vict_page_nxt = ram_rdata;
          end
          if (scan_r == last_r) begin
            state_nxt = S_UPDATE;
          end else begin
            scan_nxt = scan_r + IDX_W'(1);
          end
        end
      end
      S_UPDATE: begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if ((IDX_W'(i) != upd_slot) && valid_r[i] && (age_all || (rank_r[i] < old_rank)))
          begin
            rank_nxt[i] = rank_r[i] + IDX_W'(1);
          end
        end
        rank_nxt[upd_slot]  = '0;
        valid_nxt[upd_slot] = 1'b1;
        slot_nxt            = upd_slot;
        evict_valid_nxt     = !hit_r && !empty_found_r;
        evict_page_nxt      = (!hit_r && !empty_found_r) ? vict_page_r : '0;
        if (!hit_r && (miss_r != '1)) begin
          miss_nxt = miss_r + FAULT_W'(1);
        end
        state_nxt = S_DELIVER;
      end
      S_DELIVER: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt    = 1'b1;
          out_hit_nxt      = hit_r;
          out_slot_nxt     = slot_wide[SLOT_W-1:0];
          out_ev_valid_nxt = evict_valid_r;
          out_ev_page_nxt  = evict_page_r;
          out_fault_nxt    = miss_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cfg_frames_r  <= CFG_W'(CFG_RESET);
      valid_r       <= '0;
      miss_r        <= '0;
      out_valid_r   <= 1'b0;
      hit_r         <= 1'b0;
      empty_found_r <= 1'b0;
      scan_r        <= '0;
      last_r        <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      if (cfg_chan.valid) begin
        cfg_frames_r <= cfg_chan.frames_in_use;
      end
      valid_r       <= valid_nxt;
      miss_r        <= miss_nxt;
      out_valid_r   <= out_valid_nxt;
      hit_r         <= hit_nxt;
      empty_found_r <= empty_found_nxt;
      scan_r        <= scan_nxt;
      last_r        <= last_nxt;
      rank_r        <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r         <= page_nxt;
    slot_r         <= slot_nxt;
    empty_idx_r    <= empty_idx_nxt;
    vict_idx_r     <= vict_idx_nxt;
    vict_rank_r    <= vict_rank_nxt;
    vict_page_r    <= vict_page_nxt;
    evict_valid_r  <= evict_valid_nxt;
    evict_page_r   <= evict_page_nxt;
    out_hit_r      <= out_hit_nxt;
    out_slot_r     <= out_slot_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_page_r  <= out_ev_page_nxt;
    out_fault_r    <= out_fault_nxt;
  end

endmodule

// ----- rtl/lrupr_ram.sv -----
module lrupr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
